/* rtl/sliding_window_minimum_defines.svh */
// Assertion macros for the sliding window minimum block.
// Included by the top level only; expects clk and rst_n in scope.
`ifndef SLIDING_WINDOW_MINIMUM_DEFINES_SVH
`define SLIDING_WINDOW_MINIMUM_DEFINES_SVH

// Condition that must hold at every clock edge out of reset.
`define SWM_ASSERT_HOLD(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define SWM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/swm_pkg.sv */
// Shared types and constants for the sliding window minimum block.
// No dependencies; used by swm_cell and sliding_window_minimum.
`timescale 1ns / 1ps
`default_nettype none

package swm_pkg;

  // width of the window length register
  localparam int CFG_W = 7;

  // per-cycle command broadcast to every cell of the chain
  typedef struct packed {
    logic load;   // sample transfer: evict larger entries, append new one
    logic shift;  // drop the head entry, every cell takes its neighbour
  } ctl_t;

endpackage

`default_nettype wire

/* rtl/sliding_window_minimum.sv */
// Latency: window_min of a sample is registered and valid the cycle after its transfer.
// Throughput: one sample per cycle unless out_stall is high; a lowered window_length
// stalls input while two head entries have expired (the chain drops one per cycle).
// Reset: synchronous active-low rst_n empties the store, zeroes the sample position
// and sets window_length to 1; no clearing pass.
// Top level of the sliding window minimum; chain of swm_cell, uses swm_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "sliding_window_minimum_defines.svh"

module sliding_window_minimum
  import swm_pkg::*;
#(
  parameter int WINDOW_MAX   = 64,
  parameter int SAMPLE_WIDTH = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic signed [SAMPLE_WIDTH-1:0] in_sample,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic signed [SAMPLE_WIDTH-1:0]      out_window_min,
  input  wire logic                           cfg_we,
  input  wire logic [CFG_W-1:0]               cfg_wdata
);

  localparam int SW = SAMPLE_WIDTH;
  localparam int W  = WINDOW_MAX;
  localparam int PW = $clog2(2 * W);
  localparam int CW = (PW > CFG_W) ? PW : CFG_W;
  localparam logic [PW:0]   POS_MOD = (PW+1)'(2 * W);
  localparam logic [PW-1:0] POS_TOP = PW'(2 * W - 1);
  localparam logic [CW-1:0] LEN_MAX = CW'(W);

  logic [CFG_W-1:0]      window_length_r;
  logic [PW-1:0]         pos_r;
  logic                  out_valid_r;
  logic signed [SW-1:0]  out_min_r;

  logic [CW-1:0]         wl;
  logic [CW-1:0]         len;
  logic [PW:0]           diff0, diff1, agew0, agew1;
  logic                  exp0, exp1;
  logic                  in_xfer;
  ctl_t                  ctl;

  logic                  keep_q [W];
  logic [W-1:0]          vld_q;
  logic signed [SW-1:0]  val_q  [W];
  logic [PW-1:0]         pos_q  [W];
  logic signed [SW-1:0]  vnx_q  [W];

  // effective window length: zero means one, saturate at the store depth
  always_comb begin
    wl = CW'(window_length_r);
    priority if (wl == '0) begin
      len = CW'(1);
    end else if (wl > LEN_MAX) begin
      len = LEN_MAX;
    end else begin
      len = wl;
    end
  end

  // ages of the two oldest entries, positions modulo twice the depth
  always_comb begin
    diff0 = {1'b0, pos_r} - {1'b0, pos_q[0]};
    diff1 = {1'b0, pos_r} - {1'b0, pos_q[1]};
    agew0 = diff0[PW] ? diff0 + POS_MOD : diff0;
    agew1 = diff1[PW] ? diff1 + POS_MOD : diff1;
  end

  assign exp0 = vld_q[0] && (CW'(agew0[PW-1:0]) >= len);
  assign exp1 = vld_q[1] && (CW'(agew1[PW-1:0]) >= len);

  // two or more expired entries: drop one per cycle before taking the sample; a held result also stalls
  assign in_stall = (exp0 && exp1) || (out_valid_r && out_stall);
  assign in_xfer  = in_valid && !in_stall;

  always_comb begin
    ctl.load  = in_xfer;
    ctl.shift = in_valid && exp0;
  end

  for (genvar i = 0; i < W; i++) begin : g_cell
    logic                 prev_keep;
    logic                 nb_vld;
    logic signed [SW-1:0] nb_val;
    logic [PW-1:0]        nb_pos;

    if (i == 0) begin : g_head
      assign prev_keep = 1'b1;
    end else begin : g_body
      assign prev_keep = keep_q[i-1];
    end

    if (i == W - 1) begin : g_tail
      assign nb_vld = 1'b0;
      assign nb_val = '0;
      assign nb_pos = '0;
    end else begin : g_link
      assign nb_vld = vld_q[i+1];
      assign nb_val = val_q[i+1];
      assign nb_pos = pos_q[i+1];
    end

    swm_cell #(
      .SW (SW),
      .PW (PW)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .smp       (in_sample),
      .smp_pos   (pos_r),
      .prev_keep (prev_keep),
      .nb_vld    (nb_vld),
      .nb_val    (nb_val),
      .nb_pos    (nb_pos),
      .keep      (keep_q[i]),
      .vld       (vld_q[i]),
      .val       (val_q[i]),
      .pos       (pos_q[i]),
      .val_nxt   (vnx_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_length_r <= CFG_W'(1);
      pos_r           <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        window_length_r <= cfg_wdata;
      end
      if (in_xfer) begin
        pos_r       <= (pos_r == POS_TOP) ? '0 : pos_r + PW'(1);
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // head of the store after the transfer is the window minimum
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_min_r <= vnx_q[0];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_window_min = out_min_r;

  // occupied cells always form an unbroken run from the head
  `SWM_ASSERT_HOLD(a_vld_contig, ((vld_q >> 1) & ~vld_q) == '0, "store has a gap")
  // every transfer leaves a non-empty store whose head is the presented result
  `SWM_ASSERT_NEXT(a_head_out, in_xfer, out_valid_r && vld_q[0] && (out_min_r == val_q[0]), "result differs from store head")

endmodule

`default_nettype wire

/* rtl/swm_cell.sv */
// One cell of the monotonic store: valid flag, sample value and position.
// Depends on swm_pkg for the chain command struct.
`timescale 1ns / 1ps
`default_nettype none

module swm_cell
  import swm_pkg::*;
#(
  parameter int SW = 16,
  parameter int PW = 7
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire ctl_t                 ctl,
  input  wire logic signed [SW-1:0] smp,
  input  wire logic [PW-1:0]        smp_pos,
  input  wire logic                 prev_keep,
  input  wire logic                 nb_vld,
  input  wire logic signed [SW-1:0] nb_val,
  input  wire logic [PW-1:0]        nb_pos,
  output logic                      keep,
  output logic                      vld,
  output logic signed [SW-1:0]      val,
  output logic [PW-1:0]             pos,
  output logic signed [SW-1:0]      val_nxt
);

  logic                 vld_r, vld_nxt;
  logic signed [SW-1:0] val_r, val_nxt_c;
  logic [PW-1:0]        pos_r, pos_nxt;
  logic                 view_vld;
  logic signed [SW-1:0] view_val;
  logic [PW-1:0]        view_pos;
  logic                 take;

  // entry as seen after an optional head drop
  always_comb begin
    view_vld = ctl.shift ? nb_vld : vld_r;
    view_val = ctl.shift ? nb_val : val_r;
    view_pos = ctl.shift ? nb_pos : pos_r;
  end

  assign keep = view_vld && !(view_val > smp);
  // new sample lands in the first cell whose entry is evicted or empty
  assign take = !keep && prev_keep;

  always_comb begin
    vld_nxt   = vld_r;
    val_nxt_c = val_r;
    pos_nxt   = pos_r;
    priority if (ctl.load) begin
      vld_nxt   = keep || take;
      val_nxt_c = keep ? view_val : smp;
      pos_nxt   = keep ? view_pos : smp_pos;
    end else if (ctl.shift) begin
      vld_nxt   = nb_vld;
      val_nxt_c = nb_val;
      pos_nxt   = nb_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt_c;
    pos_r <= pos_nxt;
  end

  assign vld     = vld_r;
  assign val     = val_r;
  assign pos     = pos_r;
  assign val_nxt = val_nxt_c;

endmodule

`default_nettype wire
